// File: hw/rtl/bpsm_pkg.sv
// ----------------------------------------------------------------------------
// bpsm_pkg
// shared types and constants of the buffer pool manager: action, block state
// and status codes, register indexes, field widths, controller command bundle
// ----------------------------------------------------------------------------
package bpsm_pkg;

  // field widths
  localparam int ACT_W      = 3;
  localparam int IDX_IN_W   = 5;
  localparam int BYTES_IN_W = 32;
  localparam int TIME_W     = 64;
  localparam int STAT_W     = 2;
  localparam int GRANT_W    = 4;
  localparam int CAP_W      = 17;
  localparam int SEQ_W      = 32;
  localparam int CNT_W      = 32;
  localparam int NBLK_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // smallest legal pool
  localparam int MIN_BLOCKS = 2;

  // register reset values
  localparam logic              RST_DROP_POLICY   = 1'b0;
  localparam logic [NBLK_W-1:0] RST_BLOCKS_IN_USE = 5'd16;
  localparam logic [CAP_W-1:0]  RST_CAPACITY      = 17'd4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CAPACITY = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PROD_ACQUIRE = 3'd0,
    ACT_PROD_COMMIT  = 3'd1,
    ACT_CONS_ACQUIRE = 3'd2,
    ACT_CONS_RELEASE = 3'd3,
    ACT_OUT_ACQUIRE  = 3'd4,
    ACT_OUT_COMMIT   = 3'd5,
    ACT_CLEAR        = 3'd6,
    ACT_UNUSED       = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    BLK_FREE      = 3'd0,
    BLK_OWNED     = 3'd1,
    BLK_READY     = 3'd2,
    BLK_PROC      = 3'd3,
    BLK_OUT_READY = 3'd4
  } blk_state_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_WOULD_BLOCK = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_clr;
    logic scan_issue;
    logic drop_apply;
    logic load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_status_t;

endpackage

// File: hw/rtl/bpsm_ctrl.sv
// ----------------------------------------------------------------------------
// bpsm_ctrl
// sequencer of the pool manager: capture, execute, optional oldest-block scan,
// result load; owns both channel handshakes
// ----------------------------------------------------------------------------
module bpsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bpsm_pkg::dp_status_t status,
  output bpsm_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DROP  = 6'b010000,
    S_LOAD  = 6'b100000
  } fsm_t;

  fsm_t fsm_r, fsm_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (fsm_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    fsm_nxt       = fsm_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (fsm_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          fsm_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.scan_clr = status.need_scan;
        fsm_nxt      = status.need_scan ? S_SCAN : S_LOAD;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          fsm_nxt = S_DRAIN;
        end
      end
      // last sequence read is compared here
      S_DRAIN: begin
        fsm_nxt = S_DROP;
      end
      S_DROP: begin
        cmd.drop_apply = 1'b1;
        fsm_nxt        = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          fsm_nxt       = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/bpsm_dp.sv
// ----------------------------------------------------------------------------
// bpsm_dp
// datapath of the pool manager: block state flops, byte/sequence/time
// memories, event counters, oldest-ready scan and result registers
// ----------------------------------------------------------------------------
module bpsm_dp #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bpsm_pkg::dp_cmd_t                   cmd,
  output bpsm_pkg::dp_status_t                status,
  input  logic                                drop_policy,
  input  logic [bpsm_pkg::NBLK_W-1:0]         blocks_in_use,
  input  logic [bpsm_pkg::CAP_W-1:0]          block_capacity,
  input  logic [bpsm_pkg::ACT_W-1:0]          in_action,
  input  logic [bpsm_pkg::IDX_IN_W-1:0]       in_block_index,
  input  logic [bpsm_pkg::BYTES_IN_W-1:0]     in_byte_count,
  input  logic                                in_has_timestamp,
  input  logic [bpsm_pkg::TIME_W-1:0]         in_time_stamp,
  output logic [bpsm_pkg::STAT_W-1:0]         out_status,
  output logic [bpsm_pkg::GRANT_W-1:0]        out_granted_block,
  output logic [bpsm_pkg::CAP_W-1:0]          out_granted_bytes,
  output logic [bpsm_pkg::SEQ_W-1:0]          out_granted_sequence,
  output logic [bpsm_pkg::TIME_W-1:0]         out_granted_time,
  output logic                                out_ready_notify,
  output logic [bpsm_pkg::CNT_W-1:0]          out_overrun_total,
  output logic [bpsm_pkg::CNT_W-1:0]          out_drop_total,
  output logic [bpsm_pkg::CNT_W-1:0]          out_corrupt_total,
  output logic [bpsm_pkg::CNT_W-1:0]          out_underrun_total
);

  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BW  = (IW > bpsm_pkg::NBLK_W) ? IW : bpsm_pkg::NBLK_W;
  localparam int CW  = BW + 1;
  localparam int SW  = bpsm_pkg::SEQ_W;
  localparam int TW  = bpsm_pkg::TIME_W;
  localparam int KW  = bpsm_pkg::CAP_W;
  localparam int NW  = bpsm_pkg::CNT_W;

  function automatic logic [IW-1:0] lowest_set(input logic [MAX_BLOCKS-1:0] vec);
    logic [IW-1:0] pos;
    pos = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = IW'(i);
      end
    end
    return pos;
  endfunction

  // captured item
  bpsm_pkg::action_t                   act_r;
  logic [bpsm_pkg::IDX_IN_W-1:0]       idx_r;
  logic [bpsm_pkg::BYTES_IN_W-1:0]     bytes_r;
  logic                                has_ts_r;
  logic [TW-1:0]                       ts_r;

  // pool state
  bpsm_pkg::blk_state_t blk_r [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] time_vld_r;
  logic [SW-1:0]         seq_ctr_r;
  logic [NW-1:0]         overrun_r, drop_r, corrupt_r, underrun_r;

  logic [SW-1:0] seq_mem   [MAX_BLOCKS];
  logic [KW-1:0] bytes_mem [MAX_BLOCKS];
  logic [TW-1:0] time_mem  [MAX_BLOCKS];

  logic [SW-1:0] seq_rd_r;
  logic [KW-1:0] bytes_rd_r;
  logic [TW-1:0] time_rd_r;
  logic          tv_rd_r;

  // oldest-ready scan
  logic [IW-1:0] scan_idx_r, cmp_idx_r, pick_r;
  logic          cmp_vld_r;
  logic [SW-1:0] best_r;

  // staged result
  bpsm_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]     res_block_r, res_block_nxt;
  logic              res_notify_r, res_notify_nxt;
  logic              res_grant_r, res_grant_nxt;

  // output registers
  bpsm_pkg::status_t out_status_r;
  logic [CW-1:0]     out_block_r;
  logic [KW-1:0]     out_bytes_r;
  logic [SW-1:0]     out_seq_r;
  logic [TW-1:0]     out_time_r;
  logic              out_notify_r;
  logic [NW-1:0]     out_overrun_r, out_drop_r, out_corrupt_r, out_underrun_r;

  logic [CW-1:0]         n_ext, idx_ext;
  logic [IW-1:0]         idx_sel, free_slot, ready_slot, rd_addr;
  logic [MAX_BLOCKS-1:0] free_vec, ready_vec;
  logic                  any_free, any_ready, pool_ok, idx_ok, cap_ok, valid_op;
  bpsm_pkg::blk_state_t  idx_state;
  logic                  rd_en, cmp_hit;

  // exec update controls
  logic                  clear_all, set_en;
  logic [IW-1:0]         set_idx;
  bpsm_pkg::blk_state_t  set_val;
  logic                  inc_overrun, inc_drop, inc_corrupt, inc_underrun;
  logic                  wr_bytes, wr_seq, wr_time;

  assign n_ext   = CW'(blocks_in_use);
  assign idx_ext = CW'(idx_r);
  assign idx_sel = idx_ext[IW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free_vec[i]  = (CW'(i) < n_ext) && (blk_r[i] == bpsm_pkg::BLK_FREE);
      ready_vec[i] = (CW'(i) < n_ext) && (blk_r[i] == bpsm_pkg::BLK_READY);
    end
  end

  assign any_free   = |free_vec;
  assign any_ready  = |ready_vec;
  assign free_slot  = lowest_set(free_vec);
  assign ready_slot = lowest_set(ready_vec);
  assign pool_ok    = (n_ext >= CW'(bpsm_pkg::MIN_BLOCKS)) && (n_ext <= CW'(MAX_BLOCKS));
  assign idx_ok     = idx_ext < n_ext;
  assign idx_state  = blk_r[idx_sel];
  assign cap_ok     = bytes_r <= bpsm_pkg::BYTES_IN_W'(block_capacity);
  assign valid_op   = pool_ok && (act_r != bpsm_pkg::ACT_UNUSED) &&
                      (act_r != bpsm_pkg::ACT_CLEAR);

  assign status.need_scan = valid_op && (act_r == bpsm_pkg::ACT_PROD_ACQUIRE) &&
                            !any_free && drop_policy && any_ready;
  assign status.scan_last = CW'(scan_idx_r) == (n_ext - 1'b1);

  always_comb begin
    clear_all      = 1'b0;
    set_en         = 1'b0;
    set_idx        = idx_sel;
    set_val        = bpsm_pkg::BLK_FREE;
    inc_overrun    = 1'b0;
    inc_drop       = 1'b0;
    inc_corrupt    = 1'b0;
    inc_underrun   = 1'b0;
    wr_bytes       = 1'b0;
    wr_seq         = 1'b0;
    wr_time        = 1'b0;
    res_status_nxt = bpsm_pkg::ST_OK;
    res_block_nxt  = '0;
    res_notify_nxt = 1'b0;
    res_grant_nxt  = 1'b0;
    if (act_r == bpsm_pkg::ACT_CLEAR) begin
      clear_all = 1'b1;
    end else if (!valid_op) begin
      res_status_nxt = bpsm_pkg::ST_INVALID;
    end else begin
      case (act_r)
        bpsm_pkg::ACT_PROD_ACQUIRE, bpsm_pkg::ACT_OUT_ACQUIRE: begin
          if (any_free) begin
            set_en        = 1'b1;
            set_idx       = free_slot;
            set_val       = bpsm_pkg::BLK_OWNED;
            res_block_nxt = free_slot;
          end else begin
            inc_overrun = 1'b1;
            // drop-oldest case is finished after the scan
            if (!status.need_scan) begin
              inc_drop       = (act_r == bpsm_pkg::ACT_PROD_ACQUIRE);
              res_status_nxt = bpsm_pkg::ST_OVERFLOW;
            end
          end
        end
        bpsm_pkg::ACT_PROD_COMMIT, bpsm_pkg::ACT_OUT_COMMIT: begin
          if (!idx_ok || (idx_state != bpsm_pkg::BLK_OWNED) || !cap_ok) begin
            inc_corrupt    = 1'b1;
            res_status_nxt = bpsm_pkg::ST_INVALID;
          end else begin
            wr_bytes = 1'b1;
            wr_time  = has_ts_r;
            set_en   = 1'b1;
            if (act_r == bpsm_pkg::ACT_PROD_COMMIT) begin
              wr_seq         = 1'b1;
              set_val        = bpsm_pkg::BLK_READY;
              res_notify_nxt = 1'b1;
            end else begin
              set_val = bpsm_pkg::BLK_OUT_READY;
            end
          end
        end
        bpsm_pkg::ACT_CONS_ACQUIRE: begin
          if (any_ready) begin
            set_en        = 1'b1;
            set_idx       = ready_slot;
            set_val       = bpsm_pkg::BLK_PROC;
            res_block_nxt = ready_slot;
            res_grant_nxt = 1'b1;
          end else begin
            inc_underrun   = 1'b1;
            res_status_nxt = bpsm_pkg::ST_WOULD_BLOCK;
          end
        end
        bpsm_pkg::ACT_CONS_RELEASE: begin
          if (!idx_ok || ((idx_state != bpsm_pkg::BLK_PROC) &&
                          (idx_state != bpsm_pkg::BLK_OUT_READY))) begin
            inc_corrupt    = 1'b1;
            res_status_nxt = bpsm_pkg::ST_INVALID;
          end else begin
            set_en  = 1'b1;
            set_val = bpsm_pkg::BLK_FREE;
          end
        end
        default: begin
          res_status_nxt = bpsm_pkg::ST_INVALID;
        end
      endcase
    end
  end

  // memory read port: scan address or the granted ready block
  assign rd_en   = cmd.exec || cmd.scan_issue;
  assign rd_addr = cmd.scan_issue ? scan_idx_r : ready_slot;
  assign cmp_hit = cmp_vld_r && ready_vec[cmp_idx_r] && (seq_rd_r <= best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        blk_r[i] <= bpsm_pkg::BLK_FREE;
      end
      time_vld_r <= '0;
      seq_ctr_r  <= '0;
      overrun_r  <= '0;
      drop_r     <= '0;
      corrupt_r  <= '0;
      underrun_r <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_issue;
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.exec) begin
        if (clear_all) begin
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_r[i] <= bpsm_pkg::BLK_FREE;
          end
          overrun_r  <= '0;
          drop_r     <= '0;
          corrupt_r  <= '0;
          underrun_r <= '0;
        end
        if (set_en) begin
          blk_r[set_idx] <= set_val;
        end
        if (inc_overrun) begin
          overrun_r <= overrun_r + 1'b1;
        end
        if (inc_drop) begin
          drop_r <= drop_r + 1'b1;
        end
        if (inc_corrupt) begin
          corrupt_r <= corrupt_r + 1'b1;
        end
        if (inc_underrun) begin
          underrun_r <= underrun_r + 1'b1;
        end
        if (wr_seq) begin
          seq_ctr_r <= seq_ctr_r + 1'b1;
        end
        if (wr_time) begin
          time_vld_r[idx_sel] <= 1'b1;
        end
      end
      // oldest ready block is handed straight to the producer
      if (cmd.drop_apply) begin
        blk_r[pick_r] <= bpsm_pkg::BLK_OWNED;
        drop_r        <= drop_r + 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_seq) begin
      seq_mem[idx_sel] <= seq_ctr_r + 1'b1;
    end
    if (cmd.exec && wr_bytes) begin
      bytes_mem[idx_sel] <= bytes_r[KW-1:0];
    end
    if (cmd.exec && wr_time) begin
      time_mem[idx_sel] <= ts_r;
    end
    if (rd_en) begin
      seq_rd_r   <= seq_mem[rd_addr];
      bytes_rd_r <= bytes_mem[rd_addr];
      time_rd_r  <= time_mem[rd_addr];
      tv_rd_r    <= time_vld_r[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= bpsm_pkg::action_t'(in_action);
      idx_r    <= in_block_index;
      bytes_r  <= in_byte_count;
      has_ts_r <= in_has_timestamp;
      ts_r     <= in_time_stamp;
    end
    if (cmd.scan_clr) begin
      best_r <= '1;
      pick_r <= '0;
    end else if (cmp_hit) begin
      best_r <= seq_rd_r;
      pick_r <= cmp_idx_r;
    end
    cmp_idx_r <= scan_idx_r;
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_block_r  <= res_block_nxt;
      res_notify_r <= res_notify_nxt;
      res_grant_r  <= res_grant_nxt;
    end else if (cmd.drop_apply) begin
      res_status_r <= bpsm_pkg::ST_OK;
      res_block_r  <= pick_r;
    end
    if (cmd.load) begin
      out_status_r   <= res_status_r;
      out_block_r    <= CW'(res_block_r);
      out_bytes_r    <= res_grant_r ? bytes_rd_r : '0;
      out_seq_r      <= res_grant_r ? seq_rd_r : '0;
      out_time_r     <= (res_grant_r && tv_rd_r) ? time_rd_r : '0;
      out_notify_r   <= res_notify_r;
      out_overrun_r  <= overrun_r;
      out_drop_r     <= drop_r;
      out_corrupt_r  <= corrupt_r;
      out_underrun_r <= underrun_r;
    end
  end

  assign out_status           = out_status_r;
  assign out_granted_block    = out_block_r[bpsm_pkg::GRANT_W-1:0];
  assign out_granted_bytes    = out_bytes_r;
  assign out_granted_sequence = out_seq_r;
  assign out_granted_time     = out_time_r;
  assign out_ready_notify     = out_notify_r;
  assign out_overrun_total    = out_overrun_r;
  assign out_drop_total       = out_drop_r;
  assign out_corrupt_total    = out_corrupt_r;
  assign out_underrun_total   = out_underrun_r;

endmodule

// File: hw/rtl/block_pool_stream_manager.sv
// Buffer pool manager for one producer and one consumer. Each action item
// (acquire, commit, release, clear) returns exactly one result item with a
// status, the granted block and its metadata, and the four event counters.
// An ordinary item runs capture, execute and result load in the controller
// sequence; a producer acquire on a full pool under the drop-oldest policy
// with a ready block also runs a scan over blocks_in_use blocks, reading one
// sequence word per cycle from the sequence memory, then drain and drop steps
// before the result load. A new item is accepted while the previous result
// still waits in the output register. Registers must be written only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// block_pool_stream_manager
// top level: configuration registers, controller and datapath
// ----------------------------------------------------------------------------
module block_pool_stream_manager #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [bpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // action items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bpsm_pkg::ACT_W-1:0]          in_action,
  input  logic [bpsm_pkg::IDX_IN_W-1:0]       in_block_index,
  input  logic [bpsm_pkg::BYTES_IN_W-1:0]     in_byte_count,
  input  logic                                in_has_timestamp,
  input  logic [bpsm_pkg::TIME_W-1:0]         in_time_stamp,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bpsm_pkg::STAT_W-1:0]         out_status,
  output logic [bpsm_pkg::GRANT_W-1:0]        out_granted_block,
  output logic [bpsm_pkg::CAP_W-1:0]          out_granted_bytes,
  output logic [bpsm_pkg::SEQ_W-1:0]          out_granted_sequence,
  output logic [bpsm_pkg::TIME_W-1:0]         out_granted_time,
  output logic                                out_ready_notify,
  output logic [bpsm_pkg::CNT_W-1:0]          out_overrun_total,
  output logic [bpsm_pkg::CNT_W-1:0]          out_drop_total,
  output logic [bpsm_pkg::CNT_W-1:0]          out_corrupt_total,
  output logic [bpsm_pkg::CNT_W-1:0]          out_underrun_total
);

  // configuration registers
  logic                              drop_policy_r;
  logic [bpsm_pkg::NBLK_W-1:0]       blocks_in_use_r;
  logic [bpsm_pkg::CAP_W-1:0]        block_capacity_r;

  bpsm_pkg::dp_cmd_t    cmd;
  bpsm_pkg::dp_status_t dp_status;

  // writes to an unused index are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_policy_r    <= bpsm_pkg::RST_DROP_POLICY;
      blocks_in_use_r  <= bpsm_pkg::RST_BLOCKS_IN_USE;
      block_capacity_r <= bpsm_pkg::RST_CAPACITY;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpsm_pkg::CFG_DROP_POLICY: begin
          drop_policy_r <= cfg_wdata[0];
        end
        bpsm_pkg::CFG_BLOCKS_IN_USE: begin
          blocks_in_use_r <= cfg_wdata[bpsm_pkg::NBLK_W-1:0];
        end
        bpsm_pkg::CFG_BLOCK_CAPACITY: begin
          block_capacity_r <= cfg_wdata[bpsm_pkg::CAP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer and handshakes
  bpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (cmd)
  );

  // pool state, memories, counters and result registers
  bpsm_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (dp_status),
    .drop_policy          (drop_policy_r),
    .blocks_in_use        (blocks_in_use_r),
    .block_capacity       (block_capacity_r),
    .in_action            (in_action),
    .in_block_index       (in_block_index),
    .in_byte_count        (in_byte_count),
    .in_has_timestamp     (in_has_timestamp),
    .in_time_stamp        (in_time_stamp),
    .out_status           (out_status),
    .out_granted_block    (out_granted_block),
    .out_granted_bytes    (out_granted_bytes),
    .out_granted_sequence (out_granted_sequence),
    .out_granted_time     (out_granted_time),
    .out_ready_notify     (out_ready_notify),
    .out_overrun_total    (out_overrun_total),
    .out_drop_total       (out_drop_total),
    .out_corrupt_total    (out_corrupt_total),
    .out_underrun_total   (out_underrun_total)
  );

endmodule
